@@ rtl/core/fcb_pkg.sv @@
`timescale 1ns / 1ps

package fcb_pkg;

  localparam int unsigned TimeWidth  = 63;
  localparam int unsigned CountWidth = 16;
  localparam int unsigned DurWidth   = 32;
  localparam int unsigned AddrWidth  = 3;
  localparam int unsigned DataWidth  = 32;

  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_RECORD  = 2'd1,
    OP_PEEK    = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    OC_OK          = 3'd0,
    OC_UNAVAILABLE = 3'd1,
    OC_TIMED_OUT   = 3'd2,
    OC_REJECTED    = 3'd3,
    OC_UNKNOWN     = 3'd4,
    OC_CIRCUIT_OPEN = 3'd5
  } outcome_t;

  typedef enum logic [1:0] {
    ST_CLOSED = 2'd0,
    ST_OPEN   = 2'd1,
    ST_HALF   = 2'd2
  } circuit_t;

  typedef enum logic {
    REG_THRESHOLD = 1'b0,
    REG_DURATION  = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [1:0]           opcode;
    logic [2:0]           outcome_code;
    logic [TimeWidth-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic       granted;
    logic [1:0] circuit_state;
  } out_item_t;

  typedef struct packed {
    logic [CountWidth-1:0] failure_threshold;
    logic [DurWidth-1:0]   open_duration_ms;
  } cfg_t;

endpackage

@@ rtl/core/failure_circuit_breaker.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_stall   in_item (opcode, outcome_code, now_ms)
// out       output     out_valid / out_stall out_item (granted, circuit_state)
// cfg       input      APB psel/penable      paddr, pwdata, prdata
//
// Each transfer is captured in the input register and then loaded into the
// result register. One transfer per cycle is sustained while the output is
// not stalled; the 63-bit time subtract and compare sets the cycle time.
// Reset is synchronous and active high; it restores the closed state and
// the default registers.
// A stall on the output holds the result and, once the input register is
// full, stalls the input.

module failure_circuit_breaker (
  input  logic                          clk,
  input  logic                          rst,
  input  fcb_pkg::in_item_t             in_item,
  input  logic                          in_valid,
  output logic                          in_stall,
  output fcb_pkg::out_item_t            out_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fcb_pkg::AddrWidth-1:0] paddr,
  input  logic [fcb_pkg::DataWidth-1:0] pwdata,
  output logic [fcb_pkg::DataWidth-1:0] prdata,
  output logic                          pready
);
  import fcb_pkg::*;

  cfg_t cfg;

  fcb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fcb_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_item   (in_item),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_item  (out_item),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

endmodule

@@ rtl/core/fcb_cfg.sv @@
`timescale 1ns / 1ps

module fcb_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fcb_pkg::AddrWidth-1:0] paddr,
  input  logic [fcb_pkg::DataWidth-1:0] pwdata,
  output logic [fcb_pkg::DataWidth-1:0] prdata,
  output logic                         pready,
  output fcb_pkg::cfg_t                cfg
);
  import fcb_pkg::*;

  logic       wr_en;
  reg_index_t index;

  assign pready = 1'b1;
  assign index  = reg_index_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.failure_threshold <= 16'd5;
      cfg.open_duration_ms  <= 32'd30000;
    end else if (wr_en) begin
      unique case (index)
        REG_THRESHOLD: cfg.failure_threshold <= pwdata[CountWidth-1:0];
        REG_DURATION:  cfg.open_duration_ms  <= pwdata[DurWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      REG_THRESHOLD: prdata = {{(DataWidth-CountWidth){1'b0}}, cfg.failure_threshold};
      REG_DURATION:  prdata = cfg.open_duration_ms;
      default:       prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/fcb_core.sv @@
`timescale 1ns / 1ps

module fcb_core (
  input  logic              clk,
  input  logic              rst,
  input  fcb_pkg::cfg_t     cfg,
  input  fcb_pkg::in_item_t in_item,
  input  logic              in_valid,
  output logic              in_stall,
  output fcb_pkg::out_item_t out_item,
  output logic              out_valid,
  input  logic              out_stall
);
  import fcb_pkg::*;

  in_item_t              s1_item;
  logic                  s1_valid;
  logic                  advance;

  logic                  is_open;
  logic [TimeWidth-1:0]  opened_time;
  logic [CountWidth-1:0] failure_count;
  logic                  probe_used;

  logic                  is_open_next;
  logic [TimeWidth-1:0]  opened_time_next;
  logic [CountWidth-1:0] failure_count_next;
  logic                  probe_used_next;

  logic [TimeWidth:0]    diff;
  logic                  elapsed;
  circuit_t              st;
  logic                  grant;
  logic                  is_failure;
  logic                  is_clear;
  logic [CountWidth-1:0] count_inc;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;

  // The borrow of the subtraction flags time running backwards.
  assign diff    = {1'b0, s1_item.now_ms} - {1'b0, opened_time};
  assign elapsed = !diff[TimeWidth] &&
                   (diff[TimeWidth-1:0] >= {{(TimeWidth-DurWidth){1'b0}}, cfg.open_duration_ms});

  always_comb begin
    if (!is_open) begin
      st = ST_CLOSED;
    end else if (elapsed) begin
      st = ST_HALF;
    end else begin
      st = ST_OPEN;
    end
  end

  assign is_failure = (s1_item.outcome_code == OC_UNAVAILABLE) ||
                      (s1_item.outcome_code == OC_TIMED_OUT) ||
                      (s1_item.outcome_code == OC_UNKNOWN);
  assign is_clear   = (s1_item.outcome_code == OC_OK) ||
                      (s1_item.outcome_code == OC_REJECTED);
  assign count_inc  = (failure_count < cfg.failure_threshold) ?
                      failure_count + 16'd1 : failure_count;

  always_comb begin
    is_open_next       = is_open;
    opened_time_next   = opened_time;
    failure_count_next = failure_count;
    probe_used_next    = probe_used;
    grant              = 1'b0;
    unique case (s1_item.opcode)
      OP_REQUEST: begin
        if (st == ST_CLOSED) begin
          grant = 1'b1;
        end else if (st == ST_HALF && !probe_used) begin
          grant           = 1'b1;
          probe_used_next = 1'b1;
        end
      end
      OP_RECORD: begin
        if (is_clear) begin
          is_open_next       = 1'b0;
          opened_time_next   = '0;
          failure_count_next = '0;
          probe_used_next    = 1'b0;
        end else if (is_failure) begin
          if (st == ST_HALF) begin
            is_open_next     = 1'b1;
            opened_time_next = s1_item.now_ms;
            probe_used_next  = 1'b0;
          end else begin
            failure_count_next = count_inc;
            if (count_inc >= cfg.failure_threshold) begin
              is_open_next     = 1'b1;
              opened_time_next = s1_item.now_ms;
              probe_used_next  = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
      is_open       <= 1'b0;
      opened_time   <= '0;
      failure_count <= '0;
      probe_used    <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
      if (s1_valid && advance) begin
        is_open       <= is_open_next;
        opened_time   <= opened_time_next;
        failure_count <= failure_count_next;
        probe_used    <= probe_used_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= in_item;
    end
    if (s1_valid && advance) begin
      out_item.granted       <= grant;
      out_item.circuit_state <= st;
    end
  end

`ifndef SYNTHESIS
  a_grant_not_open: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_item.granted && out_item.circuit_state == ST_OPEN))
    else $error("grant issued while the circuit was open");

  a_probe_needs_open: assert property (@(posedge clk) disable iff (rst)
    probe_used |-> is_open)
    else $error("probe marked used while the circuit is closed");

  a_closed_no_stamp: assert property (@(posedge clk) disable iff (rst)
    !is_open |-> opened_time == '0)
    else $error("closed circuit carries an open time stamp");

  a_probe_taken: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance && grant && st == ST_HALF) |=> probe_used)
    else $error("half-open grant did not consume the probe");
`endif

endmodule

@@ verif/failure_circuit_breaker_tb.sv @@
`timescale 1ns / 1ps

module failure_circuit_breaker_tb;
  import fcb_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [2:0] OC_SPARE_LO = 3'd6;
  localparam logic [2:0] OC_SPARE_HI = 3'd7;
  localparam logic [TimeWidth-1:0] TIME_MAX = {TimeWidth{1'b1}};

  class breaker_predictor;
    logic [CountWidth-1:0] threshold;
    logic [DurWidth-1:0] duration;
    logic tripped;
    logic [TimeWidth-1:0] trip_time;
    logic [CountWidth-1:0] fail_count;
    logic probe_taken;
    out_item_t expected_q[$];
    int mismatches;

    function new();
      threshold = 16'd5;
      duration = 32'd30000;
      tripped = 1'b0;
      trip_time = '0;
      fail_count = '0;
      probe_taken = 1'b0;
      mismatches = 0;
    endfunction

    function void set_reg(reg_index_t r, logic [DataWidth-1:0] v);
      if (r == REG_THRESHOLD) begin
        threshold = v[CountWidth-1:0];
      end else begin
        duration = v;
      end
    endfunction

    function circuit_t state_at(logic [TimeWidth-1:0] t);
      if (!tripped) return ST_CLOSED;
      if (t < trip_time) return ST_OPEN;
      if ((t - trip_time) >= {{(TimeWidth-DurWidth){1'b0}}, duration}) return ST_HALF;
      return ST_OPEN;
    endfunction

    function void trip(logic [TimeWidth-1:0] t);
      tripped = 1'b1;
      trip_time = t;
      probe_taken = 1'b0;
    endfunction

    function void note_transfer(in_item_t it);
      circuit_t st;
      out_item_t r;
      st = state_at(it.now_ms);
      r.granted = 1'b0;
      r.circuit_state = st;
      if (it.opcode == OP_REQUEST) begin
        if (st == ST_CLOSED) begin
          r.granted = 1'b1;
        end else if (st == ST_HALF && !probe_taken) begin
          probe_taken = 1'b1;
          r.granted = 1'b1;
        end
      end else if (it.opcode == OP_RECORD) begin
        case (it.outcome_code)
          OC_OK, OC_REJECTED: begin
            fail_count = '0;
            tripped = 1'b0;
            trip_time = '0;
            probe_taken = 1'b0;
          end
          OC_UNAVAILABLE, OC_TIMED_OUT, OC_UNKNOWN: begin
            if (st == ST_HALF) begin
              trip(it.now_ms);
            end else begin
              if (fail_count < threshold) fail_count = fail_count + 16'd1;
              if (fail_count >= threshold) trip(it.now_ms);
            end
          end
          default: ;
        endcase
      end
      expected_q.push_back(r);
    endfunction

    function void note_error(string what);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $realtime, what);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        note_error($sformatf("result with no transfer pending: granted=%0d state=%0d",
                             got.granted, got.circuit_state));
        return;
      end
      want = expected_q.pop_front();
      if (got.granted !== want.granted)
        note_error($sformatf("granted: expected %0d, got %0d", want.granted, got.granted));
      if (got.circuit_state !== want.circuit_state)
        note_error($sformatf("circuit_state: expected %0d, got %0d",
                             want.circuit_state, got.circuit_state));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  in_item_t in_item = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  out_item_t out_item;
  logic out_valid;
  logic out_stall = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [DataWidth-1:0] pwdata = '0;
  logic [DataWidth-1:0] prdata;
  logic pready;

  breaker_predictor sb;
  logic [TimeWidth-1:0] cur_time = '0;
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;

  failure_circuit_breaker dut (
    .clk(clk),
    .rst(rst),
    .in_item(in_item),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .out_item(out_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[failure_circuit_breaker] ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_transfer(in_item);
      if (out_valid && !out_stall) sb.check_result(out_item);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(4, 40);
      end else begin
        stall_left = stall_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  task automatic send(in_item_t it);
    in_item <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_event(logic [1:0] op, logic [2:0] code, logic [TimeWidth-1:0] t);
    in_item_t it;
    it.opcode = op;
    it.outcome_code = code;
    it.now_ms = t;
    send(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes the register, then reads it back over the same port.
  task automatic write_reg(reg_index_t r, logic [DataWidth-1:0] v);
    logic [DataWidth-1:0] want;
    want = (r == REG_THRESHOLD) ? {{(DataWidth-CountWidth){1'b0}}, v[CountWidth-1:0]} : v;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrWidth'(r) << 2;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(r, v);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want)
      sb.note_error($sformatf("register %0d readback: expected %0h, got %0h", r, want, prdata));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_item_t next_event(logic [DataWidth-1:0] dur);
    in_item_t it;
    int unsigned sel;
    logic [63:0] delta;
    logic [63:0] raw;
    sel = $urandom_range(0, 99);
    if (sel < 40) it.opcode = OP_REQUEST;
    else if (sel < 85) it.opcode = OP_RECORD;
    else if (sel < 95) it.opcode = OP_PEEK;
    else it.opcode = OP_UNUSED;
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      case ($urandom_range(0, 2))
        0: it.outcome_code = OC_UNAVAILABLE;
        1: it.outcome_code = OC_TIMED_OUT;
        default: it.outcome_code = OC_UNKNOWN;
      endcase
    end else if (sel < 80) begin
      it.outcome_code = $urandom_range(0, 1) ? OC_OK : OC_REJECTED;
    end else begin
      it.outcome_code = 3'($urandom_range(OC_CIRCUIT_OPEN, OC_SPARE_HI));
    end
    sel = $urandom_range(0, 99);
    if (sel < 65) begin
      delta = 64'($urandom_range(0, dur)) + 64'($urandom_range(0, dur)) +
              64'($urandom_range(0, 3));
      cur_time = cur_time + delta[TimeWidth-1:0];
    end else if (sel < 78) begin
      // Land right at the half-open boundary of the current trip.
      cur_time = sb.trip_time + TimeWidth'(dur) + TimeWidth'($urandom_range(0, 2)) -
                 TimeWidth'(1);
    end else if (sel < 88) begin
    end else if (sel < 95) begin
      cur_time = cur_time - TimeWidth'($urandom_range(1, 1000));
    end else begin
      raw = {$urandom, $urandom};
      cur_time = raw[TimeWidth-1:0];
    end
    it.now_ms = cur_time;
    return it;
  endfunction

  task automatic run_phase(logic [CountWidth-1:0] thr, logic [DataWidth-1:0] dur, int n);
    int burst_left;
    int gap;
    burst_left = 0;
    drain();
    write_reg(REG_THRESHOLD, {{(DataWidth-CountWidth){1'b0}}, thr});
    write_reg(REG_DURATION, dur);
    for (int i = 0; i < n; i++) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 24);
      end
      send(next_event(dur));
      burst_left--;
    end
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_event(OP_REQUEST, OC_OK, '0);
    send_event(OP_PEEK, OC_OK, '0);
    send_event(OP_UNUSED, OC_OK, '0);
    send_event(OP_RECORD, OC_CIRCUIT_OPEN, 63'd10);
    send_event(OP_RECORD, OC_SPARE_LO, 63'd10);
    send_event(OP_RECORD, OC_SPARE_HI, 63'd10);
    send_event(OP_RECORD, OC_UNAVAILABLE, 63'd100);
    send_event(OP_RECORD, OC_TIMED_OUT, 63'd101);
    send_event(OP_RECORD, OC_UNKNOWN, 63'd102);
    send_event(OP_RECORD, OC_UNAVAILABLE, 63'd103);
    send_event(OP_RECORD, OC_TIMED_OUT, 63'd104);
    send_event(OP_REQUEST, OC_OK, 63'd200);
    send_event(OP_RECORD, OC_UNKNOWN, 63'd300);
    send_event(OP_REQUEST, OC_OK, 63'd50);
    send_event(OP_REQUEST, OC_OK, 63'd30299);
    send_event(OP_REQUEST, OC_OK, 63'd30300);
    send_event(OP_REQUEST, OC_OK, 63'd30300);
    send_event(OP_RECORD, OC_UNAVAILABLE, 63'd30301);
    send_event(OP_PEEK, OC_OK, 63'd60301);
    send_event(OP_REQUEST, OC_OK, 63'd60301);
    send_event(OP_RECORD, OC_OK, 63'd60302);
    send_event(OP_REQUEST, OC_OK, 63'd60303);
    send_event(OP_RECORD, OC_UNAVAILABLE, TIME_MAX - 1);
    send_event(OP_RECORD, OC_REJECTED, TIME_MAX);
    send_event(OP_REQUEST, OC_OK, TIME_MAX);

    cur_time = '0;
    run_phase(16'd1, 32'd0, 70);
    run_phase(16'd2, 32'd10, 80);
    run_phase(16'd3, 32'd100, 80);
    run_phase(16'd4, 32'd1000, 80);
    run_phase(16'($urandom_range(1, 6)), 32'($urandom_range(0, 500)), 80);
    run_phase(16'hFFFF, 32'hFFFF_FFFF, 40);
    run_phase(16'd0, 32'd5, 40);
    run_phase(16'd5, 32'd30000, 80);

    drain();
    repeat (6) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("[failure_circuit_breaker] OK");
    end else begin
      $display("[failure_circuit_breaker] ERROR");
    end
    $finish;
  end

endmodule
